@@ rtl/core/fpcv_pkg.sv @@
// Shared types and constants for the fp8/fp4 element converter.
package fpcv_pkg;

   localparam int unsigned OP_W   = 2;
   localparam int unsigned DATA_W = 32;

   typedef enum logic [OP_W-1:0] {
      OP_F32_TO_E4M3 = 2'd0,
      OP_E4M3_TO_F32 = 2'd1,
      OP_F32_TO_FP4  = 2'd2,
      OP_FP4_TO_F32  = 2'd3
   } op_type;

   // float32 patterns of the magnitudes an fp4 code can take
   localparam logic [31:0] FP4_MAG_BITS [8] = '{
      32'h0000_0000, 32'h3F00_0000, 32'h3F80_0000, 32'h3FC0_0000,
      32'h4000_0000, 32'h4040_0000, 32'h4080_0000, 32'h40C0_0000
   };

   // midpoints between neighboring fp4 magnitudes (0.25 .. 5.0)
   localparam logic [30:0] FP4_MID_BITS [7] = '{
      31'h3E80_0000, 31'h3F40_0000, 31'h3FA0_0000, 31'h3FE0_0000,
      31'h4020_0000, 31'h4060_0000, 31'h40A0_0000
   };

   // fp4 magnitudes in units of one half
   localparam logic [3:0] FP4_MAG_HALVES [8] = '{
      4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd6, 4'd8, 4'd12
   };

   localparam logic [30:0] E4M3_MAX_BITS = 31'h43E0_0000;  // 448.0

endpackage

@@ rtl/core/fpcv_if.sv @@
// Valid/ready channel interfaces for the converter's request and response.
interface fpcv_req_if
   import fpcv_pkg::*;
();
   logic              valid;
   logic              ready;
   op_type            operation;
   logic [DATA_W-1:0] operand_bits;

   modport source (output valid, operation, operand_bits, input ready);
   modport sink   (input valid, operation, operand_bits, output ready);
endinterface

interface fpcv_rsp_if
   import fpcv_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] result_bits;

   modport source (output valid, result_bits, input ready);
   modport sink   (input valid, result_bits, output ready);
endinterface

@@ rtl/core/fp8_fp4_element_converter.sv @@
// Top level: float32 <-> e4m3 / e2m1 element converter, two-register pipeline.
//
//  channel | dir | beat contents
//  --------+-----+-------------------------------------------
//  req     | in  | operation (2b), operand_bits (32b)
//  rsp     | out | result_bits (32b)
//
// One beat per cycle sustained while rsp is ready. A request beat is held in the
// input register, the conversion runs in one combinational pass, and the result
// lands in the output register.
// Reset (synchronous, high) clears both valid flags only.
// A stalled rsp holds the output register; the input register keeps taking
// beats while the output register drains, so a stall backs up one slot at
// a time.
module fp8_fp4_element_converter
   import fpcv_pkg::*;
(
   input logic         clock,
   input logic         reset,
   fpcv_req_if.sink    req,
   fpcv_rsp_if.source  rsp
);

   // ---------------------------------------------------------------
   // pipeline registers
   // ---------------------------------------------------------------
   logic              in_valid_ff, in_valid_in;
   op_type            in_op_ff;
   logic [DATA_W-1:0] in_bits_ff;
   logic              out_valid_ff, out_valid_in;
   logic [DATA_W-1:0] out_bits_ff, out_bits_in;

   logic out_adv;   // output register takes a new beat
   logic in_adv;    // input register takes a new beat

   assign out_adv   = !out_valid_ff || rsp.ready;
   assign in_adv    = !in_valid_ff || out_adv;
   assign req.ready = in_adv;

   assign in_valid_in  = in_adv ? req.valid : in_valid_ff;
   assign out_valid_in = out_adv ? in_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_adv) begin
         in_op_ff   <= req.operation;
         in_bits_ff <= req.operand_bits;
      end
      if (out_adv) begin
         out_bits_ff <= out_bits_in;
      end
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.result_bits = out_bits_ff;

   // ---------------------------------------------------------------
   // float32 -> e4m3
   // ---------------------------------------------------------------
   function automatic logic [7:0] to_e4m3(logic [31:0] x);
      logic [30:0] mag;
      logic [7:0]  expf;
      logic [22:0] frac;
      logic [22:0] norm;
      logic [3:0]  ebits;
      logic [4:0]  rnd;
      logic [3:0]  mant;
      logic [2:0]  cap;
      mag  = x[30:0];
      norm = '0;
      if (mag > E4M3_MAX_BITS) mag = E4M3_MAX_BITS;
      expf = mag[30:23];
      frac = mag[22:0];
      // subnormal input: shift the leading one out, keep what follows
      for (int i = 0; i < 23; i++) begin
         if (frac[i]) norm = 23'(frac << (23 - i));
      end
      if (expf == 8'd0) begin
         frac  = norm;
         ebits = 4'd0;
      end else if (expf < 8'd120) begin
         ebits = 4'd0;            // exponent floor of -7
      end else begin
         ebits = 4'(expf - 8'd120);
      end
      rnd  = {1'b0, frac[22:19]} + 5'd1;
      mant = rnd[4:1];
      cap  = (ebits == 4'd15) ? 3'd6 : 3'd7;
      if (mant > {1'b0, cap}) mant = {1'b0, cap};
      if (x[30:0] == 31'd0 || x[30:23] == 8'hFF) return 8'h00;
      return {x[31], ebits, mant[2:0]};
   endfunction

   // ---------------------------------------------------------------
   // e4m3 -> float32
   // ---------------------------------------------------------------
   function automatic logic [31:0] from_e4m3(logic [7:0] b);
      logic [7:0] ef;
      ef = {4'd0, b[6:3]} + 8'd120;
      if (b == 8'h00) return 32'd0;
      return {b[7], ef, b[2:0], 20'd0};
   endfunction

   // ---------------------------------------------------------------
   // rounded (ax - m) for ax >= 2^23, in halves of ax's ulp.
   // man: significand with hidden one, k: ulp exponent, h: m in halves.
   // ---------------------------------------------------------------
   function automatic logic [25:0] diff_halves(logic [23:0] man, logic [6:0] k,
                                               logic [3:0] h);
      logic [6:0]  hs;
      logic [7:0]  q16f;
      logic        s;
      logic [27:0] b;
      logic        up;
      logic [24:0] r;
      hs = {h, 3'b000};
      if (k >= 7'd7) begin
         q16f = 8'd0;
         s    = (h != 4'd0);
      end else begin
         q16f = {1'b0, 7'(hs >> k[2:0])};
         s    = (7'(q16f[6:0] << k[2:0]) != hs);
      end
      b = {man, 4'b0000} - {20'd0, q16f} - {27'd0, s};
      if (man == 24'h80_0000 && h != 4'd0) begin
         // drops into the binade below: half-ulp resolution
         up = b[2] && (b[1] || b[0] || s || b[3]);
         r  = b[27:3] + 25'(up);
         return {1'b0, r};
      end
      up = b[3] && (b[2] || b[1] || b[0] || s || b[4]);
      r  = {1'b0, b[27:4]} + 25'(up);
      return {r, 1'b0};
   endfunction

   // ---------------------------------------------------------------
   // float32 -> fp4: lower magnitude wins on equal rounded error
   // ---------------------------------------------------------------
   function automatic logic [3:0] to_fp4(logic [31:0] x);
      logic [30:0] ax;
      logic [7:0]  expf;
      logic        is_nan;
      logic        neg;
      logic [2:0]  idx;
      logic [25:0] err [8];
      ax     = x[30:0];
      expf   = ax[30:23];
      is_nan = (expf == 8'hFF) && (ax[22:0] != 23'd0);
      neg    = x[31] && (ax != 31'd0) && !is_nan;
      idx    = 3'd7;
      for (int i = 0; i < 8; i++) begin
         err[i] = diff_halves({1'b1, ax[22:0]}, 7'(expf - 8'd150), FP4_MAG_HALVES[i]);
      end
      if (expf == 8'hFF) begin
         idx = 3'd0;
      end else if (expf >= 8'd150) begin
         for (int i = 6; i >= 0; i--) begin
            if (err[i] == err[7]) idx = 3'(i);
         end
      end else begin
         for (int i = 6; i >= 0; i--) begin
            if (ax <= FP4_MID_BITS[i]) idx = 3'(i);
         end
      end
      return {neg, idx};
   endfunction

   // ---------------------------------------------------------------
   // conversion between the registers
   // ---------------------------------------------------------------
   always_comb begin
      unique case (in_op_ff)
         OP_F32_TO_E4M3: out_bits_in = {24'd0, to_e4m3(in_bits_ff)};
         OP_E4M3_TO_F32: out_bits_in = from_e4m3(in_bits_ff[7:0]);
         OP_F32_TO_FP4:  out_bits_in = {28'd0, to_fp4(in_bits_ff)};
         OP_FP4_TO_F32:  out_bits_in = {in_bits_ff[3], FP4_MAG_BITS[in_bits_ff[2:0]][30:0]};
         default:        out_bits_in = '0;
      endcase
   end

`ifndef SYNTHESIS
   a_req_to_stage: assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready |=> in_valid_ff)
      else $error("accepted request beat not held in input register");

   a_stage_to_rsp: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && out_adv |=> rsp.valid)
      else $error("input register beat lost on its way to rsp");

   a_fp4_width: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && in_op_ff == OP_F32_TO_FP4 |-> out_bits_in[31:4] == 28'd0)
      else $error("fp4 result wider than a nibble");

   a_e4m3_width: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && in_op_ff == OP_F32_TO_E4M3 |-> out_bits_in[31:8] == 24'd0)
      else $error("e4m3 result wider than a byte");
`endif

endmodule

@@ tb/fpcv_checker.sv @@
// Converter scoreboard: watches both channels, predicts each result, compares.
`timescale 1ns / 100ps

module fpcv_checker
   import fpcv_pkg::*;
(
   input  logic  clock,
   input  logic  reset,
   fpcv_req_if   req,
   fpcv_rsp_if   rsp,
   output int    error_count,
   output int    results_due
);

   localparam logic [7:0]  E4M3_NEG      = 8'h80;
   localparam logic [3:0]  FP4_NEG       = 4'h8;
   localparam logic [31:0] F32_NEG       = 32'h8000_0000;
   localparam logic [30:0] E4M3_TOP_MAG  = 31'h43E0_0000;  // 448.0
   localparam logic [23:0] MANT_HALF_LSB = 24'h08_0000;

   logic [31:0] result_queue[$];

   // fp4 magnitudes in halves
   localparam int MAG_HALVES [8] = '{0, 1, 2, 3, 4, 6, 8, 12};

   assign results_due = result_queue.size();

   function automatic real pow2(input int n);
      real p;
      p = 1.0;
      if (n >= 0) begin
         repeat (n) p = p * 2.0;
      end else begin
         repeat (-n) p = p / 2.0;
      end
      return p;
   endfunction

   // exact value of a finite float32 magnitude
   function automatic real f32_mag_value(input logic [30:0] m);
      if (m[30:23] == 8'd0) begin
         return real'(m[22:0]) * pow2(-149);
      end else begin
         return real'({1'b1, m[22:0]}) * pow2(int'(m[30:23]) - 150);
      end
   endfunction

   // round a non-negative value to float32, nearest-even, subnormals kept
   function automatic real to_f32(input real v);
      real m;
      real s;
      real fl;
      real r;
      int  e;
      if (v == 0.0) begin
         return 0.0;
      end
      m = v;
      e = 0;
      while (m >= 2.0) begin
         m = m / 2.0;
         e++;
      end
      while (m < 1.0) begin
         m = m * 2.0;
         e--;
      end
      if (e < -126) begin
         m = m * pow2(e + 126);
         e = -126;
      end
      s  = m * 8388608.0;
      fl = $floor(s);
      r  = s - fl;
      if (r > 0.5 || (r == 0.5 && $floor(fl / 2.0) * 2.0 != fl)) begin
         fl = fl + 1.0;
      end
      return fl * pow2(e - 23);
   endfunction

   function automatic logic [7:0] f32_to_e4m3(input logic [31:0] x);
      logic [30:0] mag;
      logic [22:0] frac;
      logic [23:0] sig;
      logic [23:0] rounded;
      logic [3:0]  mant;
      logic [3:0]  cap;
      int          e;
      mag = x[30:0];
      if (mag == 31'd0 || mag[30:23] == 8'hFF) begin
         return 8'd0;
      end
      if (mag > E4M3_TOP_MAG) begin
         mag = E4M3_TOP_MAG;
      end
      frac = mag[22:0];
      if (mag[30:23] == 8'd0) begin
         sig = {1'b0, frac};
         e   = -126;
         while (!sig[23]) begin
            sig = sig << 1;
            e--;
         end
         frac = sig[22:0];
      end else begin
         e = int'(mag[30:23]) - 127;
      end
      if (e < -7) e = -7;
      if (e > 8)  e = 8;
      rounded = {1'b0, frac} + MANT_HALF_LSB;
      mant    = rounded[23:20];
      cap     = (e == 8) ? 4'd6 : 4'd7;
      if (mant > cap) mant = cap;
      return (x[31] ? E4M3_NEG : 8'd0) | {1'b0, 4'(e + 7), mant[2:0]};
   endfunction

   function automatic logic [31:0] e4m3_to_f32(input logic [31:0] code);
      logic [7:0] b;
      b = code[7:0];
      if (b == 8'd0) begin
         return 32'd0;
      end
      return (b[7] ? F32_NEG : 32'd0) | {1'b0, 8'({4'd0, b[6:3]} + 8'd120), b[2:0], 20'd0};
   endfunction

   // nearest fp4 magnitude, errors taken as float32 differences, ties low
   function automatic logic [3:0] f32_to_fp4(input logic [31:0] x);
      real  a;
      real  err;
      real  least_err;
      logic [2:0] best;
      if (x[30:23] == 8'hFF) begin
         if (x[22:0] != 23'd0) return 4'd0;
         return x[31] ? FP4_NEG : 4'd0;
      end
      a         = f32_mag_value(x[30:0]);
      best      = 3'd0;
      least_err = to_f32(a);
      for (int i = 1; i < 8; i++) begin
         err = to_f32((a > MAG_HALVES[i] / 2.0) ? a - MAG_HALVES[i] / 2.0
                                                 : MAG_HALVES[i] / 2.0 - a);
         if (err < least_err) begin
            least_err = err;
            best      = 3'(i);
         end
      end
      return ((x[31] && x[30:0] != 31'd0) ? FP4_NEG : 4'd0) | {1'b0, best};
   endfunction

   function automatic logic [31:0] fp4_to_f32(input logic [31:0] code);
      logic [31:0] mag;
      mag = (MAG_HALVES[code[2:0]] == 0) ? 32'd0
            : {1'b0, 31'(f32_bits_of_halves(MAG_HALVES[code[2:0]]))};
      return (code[3] ? F32_NEG : 32'd0) | mag;
   endfunction

   // float32 pattern of a small positive multiple of one half
   function automatic logic [30:0] f32_bits_of_halves(input int h);
      int e;
      int s;
      e = -1;
      s = h;
      while (s >= 2) begin
         s = s / 2;
         e++;
      end
      // significand bits below the leading one, aligned to 23 bits
      return {8'(e + 127), 23'((h << (23 - (e + 1))) & 32'h7F_FFFF)};
   endfunction

   function automatic logic [31:0] convert(input op_type op, input logic [31:0] v);
      case (op)
         OP_F32_TO_E4M3: return {24'd0, f32_to_e4m3(v)};
         OP_E4M3_TO_F32: return e4m3_to_f32(v);
         OP_F32_TO_FP4:  return {28'd0, f32_to_fp4(v)};
         default:        return fp4_to_f32(v);
      endcase
   endfunction

   task automatic report(input string what);
      $display("mismatch @%0t: %s", $realtime, what);
      error_count++;
   endtask

   initial error_count = 0;

   always @(posedge clock) begin
      logic [31:0] want;
      if (!reset) begin
         if (req.valid && req.ready) begin
            result_queue.push_back(convert(req.operation, req.operand_bits));
         end
         if (rsp.valid && rsp.ready) begin
            if (result_queue.size() == 0) begin
               report($sformatf("unexpected beat result_bits=%h", rsp.result_bits));
            end else begin
               want = result_queue.pop_front();
               if (rsp.result_bits !== want) begin
                  report($sformatf("result_bits got %h want %h", rsp.result_bits, want));
               end
            end
         end
      end
   end

endmodule

@@ tb/tb.sv @@
// Testbench top: clock, reset, request/response stimulus and the verdict.
`timescale 1ns / 100ps

module tb
   import fpcv_pkg::*;
();

   localparam int RESET_CYCLES = 7;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_BEATS = 1050;
   localparam int DRAIN_CYCLES = 10;
   localparam int HOLD_CYCLES  = 300;

   logic clock;
   logic reset;

   fpcv_req_if req_ch ();
   fpcv_rsp_if rsp_ch ();

   int error_count;
   int results_due;
   int cycle_count;

   // idle rates in percent, changed per phase by the stimulus process
   int tx_idle_pct;
   int rx_idle_pct;

   // long receiver hold-off: requested here, counted in the receiver process
   logic hold_go;
   logic hold_done;
   int   hold_left;

   fp8_fp4_element_converter u_top (
      .clock (clock),
      .reset (reset),
      .req   (req_ch.sink),
      .rsp   (rsp_ch.source)
   );

   fpcv_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .error_count (error_count),
      .results_due (results_due)
   );

   initial begin
      clock = 1'b0;
   end

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run-time limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: errors");
         $finish;
      end
   end

   // receiver: random back-pressure, plus one long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_go && !hold_done) begin
         hold_done    <= 1'b1;
         hold_left    <= HOLD_CYCLES;
         rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left    <= hold_left - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   // offer one beat, hold it until taken; ready is stable by mid-cycle
   task automatic send_beat(input op_type op, input logic [31:0] bits);
      logic taken;
      while ($urandom_range(99) < tx_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.operation    <= op;
      req_ch.operand_bits <= bits;
      do begin
         @(negedge clock);
         taken = req_ch.ready;
         @(posedge clock);
      end while (!taken);
   endtask

   // float32 operand: half the time the interesting exponent band, plus edges
   function automatic logic [31:0] float_operand();
      logic [31:0] r;
      r = $urandom;
      case ($urandom_range(7))
         0, 1: ;                                               // any pattern
         2, 3, 4: r[30:23] = 8'($urandom_range(115, 136));      // around e4m3/fp4
         5: begin                                              // fp4 midpoints +- ulp
            r[30:23] = 8'($urandom_range(125, 129));
            r[22:0]  = {r[22:21], 21'd0} + 23'($urandom_range(2)) - 23'd1;
         end
         6: r[30:23] = 8'd0;                                   // subnormal
         default: r[30:23] = ($urandom_range(1)) ? 8'hFF : 8'($urandom_range(1, 114));
      endcase
      return r;
   endfunction

   task automatic random_beats(input int count);
      op_type op;
      repeat (count) begin
         op = op_type'($urandom_range(3));
         if (op == OP_F32_TO_E4M3 || op == OP_F32_TO_FP4) begin
            send_beat(op, float_operand());
         end else begin
            send_beat(op, $urandom);
         end
      end
   endtask

   initial begin
      cycle_count         = 0;
      hold_go             = 1'b0;
      hold_done           = 1'b0;
      hold_left           = 0;
      tx_idle_pct         = 9;
      rx_idle_pct         = 79;
      reset              <= 1'b1;
      req_ch.valid       <= 1'b0;
      req_ch.operation   <= OP_F32_TO_E4M3;
      req_ch.operand_bits <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // float -> e4m3: zeros, inf, NaN, clamp at 448, tiny, mantissa cap
      send_beat(OP_F32_TO_E4M3, 32'h0000_0000);
      send_beat(OP_F32_TO_E4M3, 32'h8000_0000);
      send_beat(OP_F32_TO_E4M3, 32'h7F80_0000);
      send_beat(OP_F32_TO_E4M3, 32'hFF80_0000);
      send_beat(OP_F32_TO_E4M3, 32'h7FC0_0000);
      send_beat(OP_F32_TO_E4M3, 32'h43E0_0000);
      send_beat(OP_F32_TO_E4M3, 32'h43F0_0000);
      send_beat(OP_F32_TO_E4M3, 32'hC700_0000);
      send_beat(OP_F32_TO_E4M3, 32'h0000_0001);
      send_beat(OP_F32_TO_E4M3, 32'h3C00_0000);
      send_beat(OP_F32_TO_E4M3, 32'h3FF8_0000);   // mantissa rounds past 7
      send_beat(OP_F32_TO_E4M3, 32'hC3DC_0000);
      // e4m3 -> float: zero, 0x80, top code, ignored high bits
      send_beat(OP_E4M3_TO_F32, 32'h0000_0000);
      send_beat(OP_E4M3_TO_F32, 32'h0000_0080);
      send_beat(OP_E4M3_TO_F32, 32'h0000_00FF);
      send_beat(OP_E4M3_TO_F32, 32'hFFFF_FF7F);
      // float -> fp4: ties low, huge, NaN, -inf, -0, subnormal
      send_beat(OP_F32_TO_FP4, 32'h3E80_0000);
      send_beat(OP_F32_TO_FP4, 32'hC0A0_0000);
      send_beat(OP_F32_TO_FP4, 32'h7F7F_FFFF);
      send_beat(OP_F32_TO_FP4, 32'hFFC0_0000);
      send_beat(OP_F32_TO_FP4, 32'hFF80_0000);
      send_beat(OP_F32_TO_FP4, 32'h8000_0000);
      send_beat(OP_F32_TO_FP4, 32'h8000_0001);
      // fp4 -> float: nibble 8 is -0, high bits ignored
      send_beat(OP_FP4_TO_F32, 32'h0000_0008);
      send_beat(OP_FP4_TO_F32, 32'hFFFF_FFF7);

      random_beats(RANDOM_BEATS / 3);
      tx_idle_pct = 79;
      rx_idle_pct = 9;
      random_beats(RANDOM_BEATS / 3);
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      hold_go    <= 1'b1;                         // sender keeps pushing into a full pipe
      random_beats(RANDOM_BEATS - 2 * (RANDOM_BEATS / 3));
      req_ch.valid <= 1'b0;

      while (results_due != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule
